>>> rtl/core/fgma_pkg.sv
// ----------------------------------------------------------------------------
// fgma_pkg
// Shared types, codes and helpers for the gang machine allocator.
// ----------------------------------------------------------------------------
package fgma_pkg;

  localparam int MAX_MACHINES_DEF = 64;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int MACH_LIMIT_CAP   = 64;

  localparam logic [6:0] COUNT_RESET = 7'd22;

  localparam int ID_W   = 31;
  localparam int SIZE_W = 7;
  localparam int MACH_W = 6;
  localparam int CNT_W  = 7;
  localparam int ENTRY_W = ID_W + SIZE_W;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_ZERO  = 2'd2
  } kind_t;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  typedef struct packed {
    logic take_add;
    logic refuse;
    logic take_free;
    logic scan_init;
    logic scan_step;
    logic flush;
    logic rc_init;
    logic rc_step;
  } fgma_cmd_t;

  typedef struct packed {
    logic is_free;
    logic set_end;
    logic size_zero;
    logic q_full;
    logic fits;
    logic job_done;
    logic rc_last;
  } fgma_sts_t;

  function automatic int mach_limit(input int max_machines);
    return (max_machines < MACH_LIMIT_CAP) ? max_machines : MACH_LIMIT_CAP;
  endfunction

  // clamp the programmed count to 1..lim
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] mc, input int lim);
    logic [CNT_W-1:0] c;
    if (mc == '0) begin
      c = CNT_W'(1);
    end else if (int'(mc) > lim) begin
      c = CNT_W'(lim);
    end else begin
      c = mc;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/fifo_gang_machine_allocator_core.sv
// ----------------------------------------------------------------------------
// fifo_gang_machine_allocator_core
// FIFO gang scheduler: queued jobs take the lowest-numbered free machines.
// ----------------------------------------------------------------------------
// Order: a refusal comes out in the cycle after start; a free without set_end
//   returns to idle at once. Scheduling checks each queue head in ST_FETCH and
//   then ST_CHECK, then scans machine indices from 0 upward in ST_SCAN;
//   grants come one per cycle at most.
// A machine_count write holds busy during a recount of every index below min(MAX_MACHINES, 64).
// Results cannot be stalled. Reset: all machines free, queue empty, count 22.
module fifo_gang_machine_allocator_core #(
  parameter int MAX_MACHINES = fgma_pkg::MAX_MACHINES_DEF,
  parameter int QUEUE_DEPTH  = fgma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [fgma_pkg::ID_W-1:0]   in_job_id,
  input  logic [fgma_pkg::SIZE_W-1:0] in_job_size,
  input  logic [fgma_pkg::MACH_W-1:0] in_machine,
  input  logic                        in_set_end,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic [fgma_pkg::ID_W-1:0]   out_granted_job,
  output logic [fgma_pkg::MACH_W-1:0] out_granted_machine,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fgma_pkg::*;

  fgma_cmd_t        cmd;
  fgma_sts_t        sts;
  logic [CNT_W-1:0] eff_cnt;
  logic             cfg_we;

  fgma_cfg #(
    .MAX_MACHINES (MAX_MACHINES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff_cnt (eff_cnt),
    .cfg_we  (cfg_we)
  );

  fgma_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_we (cfg_we),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  fgma_dp #(
    .MAX_MACHINES (MAX_MACHINES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .eff_cnt             (eff_cnt),
    .in_action           (in_action),
    .in_job_id           (in_job_id),
    .in_job_size         (in_job_size),
    .in_machine          (in_machine),
    .in_set_end          (in_set_end),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_granted_job     (out_granted_job),
    .out_granted_machine (out_granted_machine),
    .out_last            (out_last)
  );

endmodule

>>> rtl/core/fgma_cfg.sv
// ----------------------------------------------------------------------------
// fgma_cfg
// APB register slice holding machine_count; gives the clamped count.
// ----------------------------------------------------------------------------
module fgma_cfg #(
  parameter int MAX_MACHINES = fgma_pkg::MAX_MACHINES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [fgma_pkg::CNT_W-1:0] eff_cnt,
  output logic                       cfg_we
);
  import fgma_pkg::*;

  localparam int LIM = mach_limit(MAX_MACHINES);

  logic [CNT_W-1:0] mcount_r;
  logic [CNT_W-1:0] mcount_nxt;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == 1'b0);
  assign cfg_we = psel & penable & pwrite & hit;

  always_comb begin
    mcount_nxt = mcount_r;
    if (cfg_we) begin
      mcount_nxt = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcount_r <= COUNT_RESET;
    end else begin
      mcount_r <= mcount_nxt;
    end
  end

  assign prdata  = hit ? {{(32-CNT_W){1'b0}}, mcount_r} : 32'd0;
  assign eff_cnt = eff_count(mcount_r, LIM);

endmodule

>>> rtl/core/fgma_ctrl.sv
// ----------------------------------------------------------------------------
// fgma_ctrl
// Sequencer: request decode, queue head fetch, machine scan and recount.
// ----------------------------------------------------------------------------
module fgma_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  cfg_we,
  input  fgma_pkg::fgma_sts_t   sts,
  output fgma_pkg::fgma_cmd_t   cmd,
  output logic                  busy
);
  import fgma_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_RECOUNT = 5'b00010,
    ST_FETCH   = 5'b00100,
    ST_CHECK   = 5'b01000,
    ST_SCAN    = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        priority if (cfg_we) begin
          cmd.rc_init = 1'b1;
          state_nxt   = ST_RECOUNT;
        end else if (start) begin
          if (!sts.is_free) begin
            if (sts.size_zero || sts.q_full) begin
              cmd.refuse = 1'b1;
            end else begin
              cmd.take_add = 1'b1;
              state_nxt    = ST_FETCH;
            end
          end else begin
            cmd.take_free = 1'b1;
            if (sts.set_end) begin
              state_nxt = ST_FETCH;
            end
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RECOUNT: begin
        cmd.rc_step = 1'b1;
        if (sts.rc_last) begin
          state_nxt = ST_IDLE;
        end
      end
      // head entry read data lands at the end of this cycle
      ST_FETCH: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.fits) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end else begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.job_done) begin
          state_nxt = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/core/fgma_dp.sv
// ----------------------------------------------------------------------------
// fgma_dp
// Datapath: job queue memory, busy bitmap, free count, one-deep result hold.
// ----------------------------------------------------------------------------
module fgma_dp #(
  parameter int MAX_MACHINES = fgma_pkg::MAX_MACHINES_DEF,
  parameter int QUEUE_DEPTH  = fgma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fgma_pkg::fgma_cmd_t         cmd,
  output fgma_pkg::fgma_sts_t         sts,
  input  logic [fgma_pkg::CNT_W-1:0]  eff_cnt,
  input  logic                        in_action,
  input  logic [fgma_pkg::ID_W-1:0]   in_job_id,
  input  logic [fgma_pkg::SIZE_W-1:0] in_job_size,
  input  logic [fgma_pkg::MACH_W-1:0] in_machine,
  input  logic                        in_set_end,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic [fgma_pkg::ID_W-1:0]   out_granted_job,
  output logic [fgma_pkg::MACH_W-1:0] out_granted_machine,
  output logic                        out_last
);
  import fgma_pkg::*;

  localparam int LIM = mach_limit(MAX_MACHINES);
  localparam int MW  = $clog2(LIM);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  logic [LIM-1:0]   busy_r,  busy_nxt;
  logic [CNT_W-1:0] free_r,  free_nxt;
  logic [QW-1:0]    head_r,  head_nxt;
  logic [QW-1:0]    tail_r,  tail_nxt;
  logic [FW-1:0]    fill_r,  fill_nxt;
  logic [MW-1:0]    idx_r,   idx_nxt;
  logic [CNT_W-1:0] got_r,   got_nxt;

  logic               pend_v_r,    pend_v_nxt;
  logic [ID_W-1:0]    pend_job_r,  pend_job_nxt;
  logic [MACH_W-1:0]  pend_mach_r, pend_mach_nxt;

  logic               ov_r,    ov_nxt;
  kind_t              okind_r, okind_nxt;
  logic [ID_W-1:0]    ojob_r,  ojob_nxt;
  logic [MACH_W-1:0]  omach_r, omach_nxt;
  logic               olast_r, olast_nxt;

  logic [SIZE_W-1:0] head_need;
  logic [ID_W-1:0]   head_id;
  logic              grant_now;
  logic              job_done;
  logic              mach_ok;
  logic              idx_in;

  assign head_need = rdata_r[SIZE_W-1:0];
  assign head_id   = rdata_r[ENTRY_W-1:SIZE_W];
  assign grant_now = ~busy_r[idx_r];
  assign job_done  = grant_now && ((got_r + CNT_W'(1)) == head_need);
  assign mach_ok   = ({1'b0, in_machine} < eff_cnt);
  assign idx_in    = (CNT_W'(idx_r) < eff_cnt);

  assign sts.is_free   = (in_action == ACT_FREE);
  assign sts.set_end   = in_set_end;
  assign sts.size_zero = (in_job_size == '0);
  assign sts.q_full    = (fill_r == FW'(QUEUE_DEPTH));
  assign sts.fits      = (fill_r != '0) && (head_need <= free_r);
  assign sts.job_done  = job_done;
  assign sts.rc_last   = (idx_r == MW'(LIM - 1));

  always_comb begin
    busy_nxt      = busy_r;
    free_nxt      = free_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    got_nxt       = got_r;
    pend_v_nxt    = pend_v_r;
    pend_job_nxt  = pend_job_r;
    pend_mach_nxt = pend_mach_r;
    ov_nxt        = 1'b0;
    okind_nxt     = okind_r;
    ojob_nxt      = ojob_r;
    omach_nxt     = omach_r;
    olast_nxt     = olast_r;

    if (cmd.take_add) begin
      tail_nxt = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
      fill_nxt = fill_r + FW'(1);
    end

    if (cmd.refuse) begin
      ov_nxt    = 1'b1;
      okind_nxt = (in_job_size == '0) ? KIND_ZERO : KIND_FULL;
      ojob_nxt  = in_job_id;
      omach_nxt = '0;
      olast_nxt = 1'b1;
    end

    if (cmd.take_free) begin
      if (mach_ok && busy_r[in_machine[MW-1:0]]) begin
        busy_nxt[in_machine[MW-1:0]] = 1'b0;
        free_nxt = free_r + CNT_W'(1);
      end
    end

    if (cmd.scan_init) begin
      idx_nxt = '0;
      got_nxt = '0;
    end

    // grants are held one deep so the final one can carry last
    if (cmd.scan_step) begin
      idx_nxt = idx_r + MW'(1);
      if (grant_now) begin
        busy_nxt[idx_r] = 1'b1;
        free_nxt        = free_r - CNT_W'(1);
        got_nxt         = got_r + CNT_W'(1);
        if (pend_v_r) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_GRANT;
          ojob_nxt  = pend_job_r;
          omach_nxt = pend_mach_r;
          olast_nxt = 1'b0;
        end
        pend_v_nxt    = 1'b1;
        pend_job_nxt  = head_id;
        pend_mach_nxt = MACH_W'(idx_r);
        if (job_done) begin
          head_nxt = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
          fill_nxt = fill_r - FW'(1);
        end
      end
    end

    if (cmd.flush && pend_v_r) begin
      ov_nxt     = 1'b1;
      okind_nxt  = KIND_GRANT;
      ojob_nxt   = pend_job_r;
      omach_nxt  = pend_mach_r;
      olast_nxt  = 1'b1;
      pend_v_nxt = 1'b0;
    end

    if (cmd.rc_init) begin
      idx_nxt  = '0;
      free_nxt = '0;
    end

    // drop busy bits at or above the new count, count the free ones below it
    if (cmd.rc_step) begin
      idx_nxt = idx_r + MW'(1);
      if (!idx_in) begin
        busy_nxt[idx_r] = 1'b0;
      end else if (!busy_r[idx_r]) begin
        free_nxt = free_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= '0;
      free_r   <= eff_count(COUNT_RESET, LIM);
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      idx_r    <= '0;
      got_r    <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      free_r   <= free_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
      got_r    <= got_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r  <= pend_job_nxt;
    pend_mach_r <= pend_mach_nxt;
    okind_r     <= okind_nxt;
    ojob_r      <= ojob_nxt;
    omach_r     <= omach_nxt;
    olast_r     <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_add) begin
      mem[tail_r] <= {in_job_id, in_job_size};
    end
    rdata_r <= mem[head_r];
  end

  assign out_valid           = ov_r;
  assign out_kind            = okind_r;
  assign out_granted_job     = ojob_r;
  assign out_granted_machine = omach_r;
  assign out_last            = olast_r;

endmodule
